>>> rtl/core/position_cue_trigger_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Position cue trigger sequencer assertion macros
// Property helpers shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef POSITION_CUE_TRIGGER_SEQUENCER_MACROS_SVH
`define POSITION_CUE_TRIGGER_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCTS_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCTS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pcts_pkg.sv
// ----------------------------------------------------------------------------
// Position cue trigger sequencer package
// Sizes, reset values, register indexes, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package pcts_pkg;

    localparam int MAX_MARKERS = 64;
    localparam int PLAY_SLOTS  = 16;

    localparam int MARK_IDX_W = $clog2(MAX_MARKERS);
    localparam int MARK_CNT_W = $clog2(MAX_MARKERS + 1);
    localparam int SLOT_IDX_W = $clog2(PLAY_SLOTS);
    localparam int SLOT_CNT_W = $clog2(PLAY_SLOTS + 1);

    localparam int POS_W    = 24;
    localparam int TICKS_W  = 5;
    localparam int WINDOW_W = 17;
    localparam int GAIN_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICKS_W-1:0]  PLAY_TICKS_RST     = 5'd15;
    localparam logic [WINDOW_W-1:0] NEW_LAP_WINDOW_RST = 17'd1000;
    localparam logic [GAIN_W-1:0]   CUE_VOLUME_RST     = 8'd179;
    localparam logic [COUNT_W-1:0]  MARKER_COUNT_RST   = 7'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAY_TICKS     = 2'd0,
        CFG_NEW_LAP_WINDOW = 2'd1,
        CFG_CUE_VOLUME     = 2'd2,
        CFG_MARKER_COUNT   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_TICK   = 2'd1,
        OP_REARM  = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_LAP,
        ST_FETCH,
        ST_CMP,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/position_cue_trigger_sequencer.sv
// ----------------------------------------------------------------------------
// Position cue trigger sequencer
// Marker table, play slot walk and lap tracking for two cue channels.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   in      | in_valid / in_ready   | opcode, entry_*, lap_distance
//   out     | out_valid / out_ready | gains, restarts, next_marker, flags
//   cfg     | cfg_wen               | cfg_index, cfg_data
//
// A load, rearm or unknown request passes from idle to the finish state. A tick
// walks the slots in use, one slot per cycle through the shared decrement unit,
// then does the lap check, the registered table read and the position compare.
// A tick that stays waiting for a lap skips the read and compare.
// The last state holds while the output register is full and not drained.
// Reset clears all control state; the marker table is not cleared.
// ----------------------------------------------------------------------------
`include "position_cue_trigger_sequencer_macros.svh"

module position_cue_trigger_sequencer
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_wen,
    input  logic [pcts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcts_pkg::CFG_W-1:0]       cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       opcode,
    input  logic [pcts_pkg::MARK_IDX_W-1:0]  entry_index,
    input  logic signed [pcts_pkg::POS_W-1:0] entry_position,
    input  logic                             entry_channel,
    input  logic signed [pcts_pkg::POS_W-1:0] lap_distance,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pcts_pkg::GAIN_W-1:0]      premarker_gain,
    output logic [pcts_pkg::GAIN_W-1:0]      marker_gain,
    output logic                             premarker_restart,
    output logic                             marker_restart,
    output logic [pcts_pkg::MARK_IDX_W-1:0]  next_marker,
    output logic                             awaiting_lap,
    output logic                             slot_overflow
);

    localparam int NS = pcts_pkg::PLAY_SLOTS;
    localparam int NM = pcts_pkg::MAX_MARKERS;

    // configuration
    logic [pcts_pkg::TICKS_W-1:0]  play_ticks_reg;
    logic [pcts_pkg::WINDOW_W-1:0] window_reg;
    logic [pcts_pkg::GAIN_W-1:0]   volume_reg;
    logic [pcts_pkg::COUNT_W-1:0]  marker_count_reg;

    // sequencer
    pcts_pkg::state_t state_reg, state_next;

    // request latch
    logic [pcts_pkg::POS_W-1:0]       dist_reg, dist_next;

    // block state
    logic [pcts_pkg::MARK_IDX_W-1:0]  next_entry_reg, next_entry_next;
    logic                             lap_wait_reg, lap_wait_next;
    logic [pcts_pkg::TICKS_W-1:0]     slot_ticks_reg [NS];
    logic [pcts_pkg::TICKS_W-1:0]     slot_ticks_next [NS];
    logic                             slot_cue_reg [NS];
    logic                             slot_cue_next [NS];
    logic [pcts_pkg::SLOT_CNT_W-1:0]  slots_used_reg, slots_used_next;
    logic [pcts_pkg::GAIN_W-1:0]      gain_reg [2];
    logic [pcts_pkg::GAIN_W-1:0]      gain_next [2];

    // walk and per-request flags
    logic [pcts_pkg::SLOT_IDX_W-1:0]  slot_idx_reg, slot_idx_next;
    logic                             live_reg, live_next;
    logic [1:0]                       restart_reg, restart_next;
    logic                             overflow_reg, overflow_next;

    // marker table
    logic [pcts_pkg::POS_W-1:0]       pos_mem [NM];
    logic                             ch_mem [NM];
    logic [pcts_pkg::POS_W-1:0]       rd_pos_reg;
    logic                             rd_ch_reg;

    // result register
    logic                             out_valid_reg, out_valid_next;
    logic [pcts_pkg::GAIN_W-1:0]      out_gain0_reg, out_gain0_next;
    logic [pcts_pkg::GAIN_W-1:0]      out_gain1_reg, out_gain1_next;
    logic [1:0]                       out_restart_reg, out_restart_next;
    logic [pcts_pkg::MARK_IDX_W-1:0]  out_next_reg, out_next_next;
    logic                             out_wait_reg, out_wait_next;
    logic                             out_ovf_reg, out_ovf_next;

    // shared decode
    logic                             accept;
    logic                             load_ok;
    logic [pcts_pkg::TICKS_W-1:0]     cur_ticks;
    logic [pcts_pkg::TICKS_W-1:0]     dec_ticks;
    logic                             last_slot;
    logic                             window_hit;
    logic [pcts_pkg::MARK_CNT_W-1:0]  count;
    logic                             fire;
    logic [pcts_pkg::MARK_CNT_W-1:0]  next_inc;

    assign in_ready = (state_reg == pcts_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_ok  = !out_valid_reg || out_ready;

    assign cur_ticks = slot_ticks_reg[slot_idx_reg];
    assign dec_ticks = (cur_ticks != '0) ? cur_ticks - pcts_pkg::TICKS_W'(1) : cur_ticks;
    assign last_slot = ({1'b0, slot_idx_reg} + pcts_pkg::SLOT_CNT_W'(1)) == slots_used_reg;

    assign window_hit = ($signed(dist_reg) > $signed(pcts_pkg::POS_W'(0))) &&
                        ($signed({dist_reg[pcts_pkg::POS_W-1], dist_reg}) <
                         $signed({{(pcts_pkg::POS_W + 1 - pcts_pkg::WINDOW_W){1'b0}},
                                  window_reg}));

    // a count above the table depth acts as the depth
    assign count = (marker_count_reg > pcts_pkg::COUNT_W'(NM))
                 ? pcts_pkg::MARK_CNT_W'(NM)
                 : pcts_pkg::MARK_CNT_W'(marker_count_reg);

    assign fire = ({1'b0, next_entry_reg} < count) &&
                  ($signed(dist_reg) > $signed(rd_pos_reg));
    assign next_inc = {1'b0, next_entry_reg} + pcts_pkg::MARK_CNT_W'(fire);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_ticks_reg   <= pcts_pkg::PLAY_TICKS_RST;
            window_reg       <= pcts_pkg::NEW_LAP_WINDOW_RST;
            volume_reg       <= pcts_pkg::CUE_VOLUME_RST;
            marker_count_reg <= pcts_pkg::MARKER_COUNT_RST;
        end
        else if (cfg_wen)
        begin
            case (pcts_pkg::cfg_reg_t'(cfg_index))
                pcts_pkg::CFG_PLAY_TICKS:
                    play_ticks_reg <= cfg_data[pcts_pkg::TICKS_W-1:0];
                pcts_pkg::CFG_NEW_LAP_WINDOW:
                    window_reg <= cfg_data[pcts_pkg::WINDOW_W-1:0];
                pcts_pkg::CFG_CUE_VOLUME:
                    volume_reg <= cfg_data[pcts_pkg::GAIN_W-1:0];
                pcts_pkg::CFG_MARKER_COUNT:
                    marker_count_reg <= cfg_data[pcts_pkg::COUNT_W-1:0];
                default:
                    play_ticks_reg <= play_ticks_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // marker table: one write port, one registered read at next_entry
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == pcts_pkg::OP_LOAD))
        begin
            pos_mem[entry_index] <= entry_position;
            ch_mem[entry_index]  <= entry_channel;
        end
        rd_pos_reg <= pos_mem[next_entry_reg];
        rd_ch_reg  <= ch_mem[next_entry_reg];
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == pcts_pkg::OP_TICK)
                        state_next = (slots_used_reg != '0) ? pcts_pkg::ST_SLOT
                                                            : pcts_pkg::ST_LAP;
                    else
                        state_next = pcts_pkg::ST_FINISH;
                end
            end
            pcts_pkg::ST_SLOT:
            begin
                if (last_slot)
                    state_next = pcts_pkg::ST_LAP;
            end
            pcts_pkg::ST_LAP:
            begin
                // still waiting for a new lap: nothing more on this tick
                if (lap_wait_reg && !window_hit)
                    state_next = pcts_pkg::ST_FINISH;
                else
                    state_next = pcts_pkg::ST_FETCH;
            end
            pcts_pkg::ST_FETCH:
                state_next = pcts_pkg::ST_CMP;
            pcts_pkg::ST_CMP:
                state_next = pcts_pkg::ST_FINISH;
            pcts_pkg::ST_FINISH:
            begin
                if (load_ok)
                    state_next = pcts_pkg::ST_IDLE;
            end
            default:
                state_next = pcts_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        dist_next        = dist_reg;
        next_entry_next  = next_entry_reg;
        lap_wait_next    = lap_wait_reg;
        slot_ticks_next  = slot_ticks_reg;
        slot_cue_next    = slot_cue_reg;
        slots_used_next  = slots_used_reg;
        gain_next        = gain_reg;
        slot_idx_next    = slot_idx_reg;
        live_next        = live_reg;
        restart_next     = restart_reg;
        overflow_next    = overflow_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_gain0_next   = out_gain0_reg;
        out_gain1_next   = out_gain1_reg;
        out_restart_next = out_restart_reg;
        out_next_next    = out_next_reg;
        out_wait_next    = out_wait_reg;
        out_ovf_next     = out_ovf_reg;

        case (state_reg)
            pcts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    dist_next     = lap_distance;
                    slot_idx_next = '0;
                    live_next     = 1'b0;
                    restart_next  = '0;
                    overflow_next = 1'b0;
                    if (opcode == pcts_pkg::OP_REARM)
                    begin
                        lap_wait_next   = 1'b0;
                        next_entry_next = '0;
                    end
                end
            end
            pcts_pkg::ST_SLOT:
            begin
                // count down one slot; an expired slot mutes its channel
                slot_ticks_next[slot_idx_reg] = dec_ticks;
                if (dec_ticks == '0)
                    gain_next[slot_cue_reg[slot_idx_reg]] = '0;
                else
                    live_next = 1'b1;
                if (last_slot && !live_reg && (dec_ticks == '0))
                    slots_used_next = '0;
                slot_idx_next = slot_idx_reg + pcts_pkg::SLOT_IDX_W'(1);
            end
            pcts_pkg::ST_LAP:
            begin
                if (lap_wait_reg && window_hit)
                begin
                    lap_wait_next   = 1'b0;
                    next_entry_next = '0;
                end
            end
            pcts_pkg::ST_CMP:
            begin
                if (fire)
                begin
                    if (slots_used_reg < pcts_pkg::SLOT_CNT_W'(NS))
                    begin
                        slot_ticks_next[slots_used_reg[pcts_pkg::SLOT_IDX_W-1:0]] =
                            play_ticks_reg;
                        slot_cue_next[slots_used_reg[pcts_pkg::SLOT_IDX_W-1:0]] = rd_ch_reg;
                        slots_used_next = slots_used_reg + pcts_pkg::SLOT_CNT_W'(1);
                        gain_next[rd_ch_reg]    = volume_reg;
                        restart_next[rd_ch_reg] = 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                // wrap to waiting after the last marker
                if (next_inc >= count)
                begin
                    lap_wait_next   = 1'b1;
                    next_entry_next = '0;
                end
                else
                begin
                    next_entry_next = next_inc[pcts_pkg::MARK_IDX_W-1:0];
                end
            end
            pcts_pkg::ST_FINISH:
            begin
                if (load_ok)
                begin
                    out_valid_next   = 1'b1;
                    out_gain0_next   = gain_reg[0];
                    out_gain1_next   = gain_reg[1];
                    out_restart_next = restart_reg;
                    out_next_next    = next_entry_reg;
                    out_wait_next    = lap_wait_reg;
                    out_ovf_next     = overflow_reg;
                end
            end
            default:
                slot_idx_next = slot_idx_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pcts_pkg::ST_IDLE;
            next_entry_reg  <= '0;
            lap_wait_reg    <= 1'b0;
            slots_used_reg  <= '0;
            slot_idx_reg    <= '0;
            live_reg        <= 1'b0;
            restart_reg     <= '0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                slot_ticks_reg[i] <= '0;
                slot_cue_reg[i]   <= 1'b0;
            end
            gain_reg[0] <= '0;
            gain_reg[1] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            next_entry_reg <= next_entry_next;
            lap_wait_reg   <= lap_wait_next;
            slots_used_reg <= slots_used_next;
            slot_idx_reg   <= slot_idx_next;
            live_reg       <= live_next;
            restart_reg    <= restart_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
            slot_ticks_reg <= slot_ticks_next;
            slot_cue_reg   <= slot_cue_next;
            gain_reg       <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg        <= dist_next;
        out_gain0_reg   <= out_gain0_next;
        out_gain1_reg   <= out_gain1_next;
        out_restart_reg <= out_restart_next;
        out_next_reg    <= out_next_next;
        out_wait_reg    <= out_wait_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign out_valid         = out_valid_reg;
    assign premarker_gain    = out_gain0_reg;
    assign marker_gain       = out_gain1_reg;
    assign premarker_restart = out_restart_reg[0];
    assign marker_restart    = out_restart_reg[1];
    assign next_marker       = out_next_reg;
    assign awaiting_lap      = out_wait_reg;
    assign slot_overflow     = out_ovf_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `PCTS_ASSERT_IMPL(a_slots_bounded, clk, rst_n, 1'b1,
        slots_used_reg <= pcts_pkg::SLOT_CNT_W'(NS), "slot count past slot list")
    `PCTS_ASSERT_IMPL(a_restart_gain, clk, rst_n, out_valid_reg && out_restart_reg[1],
        out_gain1_reg == volume_reg, "restarted marker cue not at cue volume")
    `PCTS_ASSERT_IMPL(a_overflow_no_restart, clk, rst_n, out_valid_reg && out_ovf_reg,
        out_restart_reg == 2'b00, "overflow reported with a started cue")
    `PCTS_ASSERT_NEXT(a_wait_index_zero, clk, rst_n, lap_wait_reg,
        !lap_wait_reg || (next_entry_reg == '0), "waiting for lap with nonzero index")

endmodule

>>> dv/position_cue_trigger_sequencer_test.sv
// ----------------------------------------------------------------------------
// Position cue trigger sequencer testbench
// Loads marker tables and plays laps of distance requests through the
// sequencer under varied pacing. A local copy of the sequencer state predicts
// each response, which is compared field by field in order.
// ----------------------------------------------------------------------------
module position_cue_trigger_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pcts_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int GAP_PCT        = 46;
    localparam int BOTH_GAP_PCT   = 9;
    localparam int PHASES         = 12;
    localparam int PHASE_REQUESTS = 120;

    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

    typedef struct {
        opcode_t                 op;
        logic [MARK_IDX_W-1:0]   idx;
        logic signed [POS_W-1:0] pos;
        logic                    ch;
        logic signed [POS_W-1:0] lap_dist;
    } cue_req_t;

    typedef struct {
        logic [GAIN_W-1:0]     pre_gain;
        logic [GAIN_W-1:0]     mark_gain;
        logic                  pre_restart;
        logic                  mark_restart;
        logic [MARK_IDX_W-1:0] next;
        logic                  waiting;
        logic                  overflow;
    } cue_resp_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              opcode = '0;
    logic [MARK_IDX_W-1:0]   entry_index = '0;
    logic signed [POS_W-1:0] entry_position = '0;
    logic                    entry_channel = 1'b0;
    logic signed [POS_W-1:0] lap_distance = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [GAIN_W-1:0]       premarker_gain;
    logic [GAIN_W-1:0]       marker_gain;
    logic                    premarker_restart;
    logic                    marker_restart;
    logic [MARK_IDX_W-1:0]   next_marker;
    logic                    awaiting_lap;
    logic                    slot_overflow;

    position_cue_trigger_sequencer DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .entry_index       (entry_index),
        .entry_position    (entry_position),
        .entry_channel     (entry_channel),
        .lap_distance      (lap_distance),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .premarker_gain    (premarker_gain),
        .marker_gain       (marker_gain),
        .premarker_restart (premarker_restart),
        .marker_restart    (marker_restart),
        .next_marker       (next_marker),
        .awaiting_lap      (awaiting_lap),
        .slot_overflow     (slot_overflow)
    );

    // Sequencer state as predicted
    logic signed [POS_W-1:0] mark_pos [MAX_MARKERS];
    logic                    mark_ch [MAX_MARKERS];
    int                      next_idx;
    bit                      lap_wait;
    logic [TICKS_W-1:0]      slot_left [PLAY_SLOTS];
    logic                    slot_ch [PLAY_SLOTS];
    int                      slots_used;
    logic [GAIN_W-1:0]       ch_gain [2];
    logic [TICKS_W-1:0]      cfg_ticks;
    logic [WINDOW_W-1:0]     cfg_window;
    logic [GAIN_W-1:0]       cfg_volume;
    logic [COUNT_W-1:0]      cfg_count;

    cue_req_t  pending_q [$];
    cue_resp_t expected_q [$];
    pace_t     pace = PACE_FULL;
    bit        req_taken;
    bit        hold_start;
    int        hold_left;
    int        stuck_cycles;
    int        mismatches;
    int        phase_reqs;

    function automatic cue_resp_t predict_response(cue_req_t r);
        cue_resp_t o;
        int        lim;
        int        live;
        int        d;
        bit        proceed;
        logic      ch;
        o.pre_restart  = 1'b0;
        o.mark_restart = 1'b0;
        o.overflow     = 1'b0;
        lim = (cfg_count > MAX_MARKERS) ? MAX_MARKERS : int'(cfg_count);
        d   = int'(r.lap_dist);
        case (r.op)
            OP_LOAD:
            begin
                mark_pos[r.idx] = r.pos;
                mark_ch[r.idx]  = r.ch;
            end
            OP_TICK:
            begin
                // count down the slots in use; expired ones silence their channel
                if (slots_used > 0)
                begin
                    live = 0;
                    for (int i = 0; i < slots_used && i < PLAY_SLOTS; i++)
                    begin
                        if (slot_left[i] > 0)
                            slot_left[i]--;
                        if (slot_left[i] == 0)
                            ch_gain[slot_ch[i]] = '0;
                        else
                            live++;
                    end
                    if (live == 0)
                        slots_used = 0;
                end
                proceed = 1'b1;
                if (lap_wait)
                begin
                    if (d > 0 && d < int'(cfg_window))
                    begin
                        lap_wait = 1'b0;
                        next_idx = 0;
                    end
                    else
                        proceed = 1'b0;
                end
                if (proceed)
                begin
                    if (next_idx < lim && d > int'(mark_pos[next_idx]))
                    begin
                        ch = mark_ch[next_idx];
                        if (slots_used < PLAY_SLOTS)
                        begin
                            slot_left[slots_used] = cfg_ticks;
                            slot_ch[slots_used]   = ch;
                            slots_used++;
                            ch_gain[ch] = cfg_volume;
                            if (ch)
                                o.mark_restart = 1'b1;
                            else
                                o.pre_restart = 1'b1;
                        end
                        else
                            o.overflow = 1'b1;
                        next_idx++;
                    end
                    if (next_idx >= lim)
                    begin
                        lap_wait = 1'b1;
                        next_idx = 0;
                    end
                end
            end
            OP_REARM:
            begin
                lap_wait = 1'b0;
                next_idx = 0;
            end
            default: ;
        endcase
        o.pre_gain  = ch_gain[0];
        o.mark_gain = ch_gain[1];
        o.next      = MARK_IDX_W'(next_idx);
        o.waiting   = lap_wait;
        return o;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Request driver
    always @(negedge clk)
    begin : driver
        cue_req_t r;
        bit       gap;
        case (pace)
            PACE_SEND_GAPS: gap = ($urandom_range(0, 99) < GAP_PCT);
            PACE_BOTH:      gap = ($urandom_range(0, 99) < BOTH_GAP_PCT);
            default:        gap = 1'b0;
        endcase
        if (rst_n && (!in_valid || req_taken))
        begin
            if (pending_q.size() > 0 && !gap)
            begin
                r = pending_q.pop_front();
                opcode         <= r.op;
                entry_index    <= r.idx;
                entry_position <= r.pos;
                entry_channel  <= r.ch;
                lap_distance   <= r.lap_dist;
                in_valid       <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Response acceptor
    always @(negedge clk)
    begin : receiver
        bit stall;
        case (pace)
            PACE_RECV_STALLS: stall = ($urandom_range(0, 99) < GAP_PCT);
            PACE_BOTH:        stall = ($urandom_range(0, 99) < BOTH_GAP_PCT);
            default:          stall = 1'b0;
        endcase
        if (hold_start)
        begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && !stall;
    end

    always @(posedge clk)
    begin : monitor
        cue_req_t  r;
        cue_resp_t want;
        if (rst_n)
        begin
            // check the response first so a same-cycle request cannot match it
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response with none expected", $time);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("premarker_gain", want.pre_gain, premarker_gain);
                    check_field("marker_gain", want.mark_gain, marker_gain);
                    check_field("premarker_restart", want.pre_restart, premarker_restart);
                    check_field("marker_restart", want.mark_restart, marker_restart);
                    check_field("next_marker", want.next, next_marker);
                    check_field("awaiting_lap", want.waiting, awaiting_lap);
                    check_field("slot_overflow", want.overflow, slot_overflow);
                end
            end
            if (in_valid && in_ready)
            begin
                req_taken = 1'b1;
                r.op       = opcode_t'(opcode);
                r.idx      = entry_index;
                r.pos      = entry_position;
                r.ch       = entry_channel;
                r.lap_dist = lap_distance;
                expected_q = {expected_q, predict_response(r)};
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic cue_req_t random_req(opcode_t op);
        cue_req_t r;
        r.op       = op;
        r.idx      = MARK_IDX_W'($urandom);
        r.pos      = POS_W'($urandom);
        r.ch       = 1'($urandom);
        r.lap_dist = POS_W'($urandom);
        return r;
    endfunction

    task automatic push_req(cue_req_t r);
        pending_q = {pending_q, r};
        phase_reqs++;
    endtask

    task automatic push_load(int idx, int pos, logic ch);
        cue_req_t r;
        r     = random_req(OP_LOAD);
        r.idx = MARK_IDX_W'(idx);
        r.pos = POS_W'(pos);
        r.ch  = ch;
        push_req(r);
    endtask

    task automatic push_tick(int d);
        cue_req_t r;
        r          = random_req(OP_TICK);
        r.lap_dist = POS_W'(d);
        push_req(r);
    endtask

    task automatic settle();
        while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_reg_t sel, int unsigned value);
        logic [CFG_W-1:0] mask;
        logic [CFG_W-1:0] data;
        case (sel)
            CFG_PLAY_TICKS:     mask = CFG_W'((1 << TICKS_W) - 1);
            CFG_NEW_LAP_WINDOW: mask = CFG_W'((1 << WINDOW_W) - 1);
            CFG_CUE_VOLUME:     mask = CFG_W'((1 << GAIN_W) - 1);
            default:            mask = CFG_W'((1 << COUNT_W) - 1);
        endcase
        // random bits above the register width must be dropped
        data = (CFG_W'($urandom) & ~mask) | (CFG_W'(value) & mask);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (sel)
            CFG_PLAY_TICKS:     cfg_ticks  = data[TICKS_W-1:0];
            CFG_NEW_LAP_WINDOW: cfg_window = data[WINDOW_W-1:0];
            CFG_CUE_VOLUME:     cfg_volume = data[GAIN_W-1:0];
            default:            cfg_count  = data[COUNT_W-1:0];
        endcase
    endtask

    task automatic set_config(int ticks, int window, int volume, int count);
        write_cfg(CFG_PLAY_TICKS, ticks);
        write_cfg(CFG_NEW_LAP_WINDOW, window);
        write_cfg(CFG_CUE_VOLUME, volume);
        write_cfg(CFG_MARKER_COUNT, count);
    endtask

    function automatic int markers_in_use();
        return (cfg_count > MAX_MARKERS) ? MAX_MARKERS : int'(cfg_count);
    endfunction

    // Sorted positions, so a rising distance passes them one by one
    task automatic fill_markers();
        int pos;
        pos = int'($urandom_range(0, 1500)) - 500;
        for (int i = 0; i < markers_in_use(); i++)
        begin
            push_load(i, pos, 1'($urandom));
            pos += $urandom_range(0, 2000);
        end
    endtask

    task automatic run_lap();
        int d;
        int top;
        if (cfg_window >= 2)
        begin
            top = (int'(cfg_window) - 1 > 3000) ? 3000 : int'(cfg_window) - 1;
            d   = $urandom_range(1, top);
        end
        else
        begin
            // no distance can open a lap; rearm instead
            push_req(random_req(OP_REARM));
            d = int'($urandom_range(0, 400)) - 200;
        end
        repeat (markers_in_use() + $urandom_range(2, 6))
        begin
            push_tick(d);
            if ($urandom_range(0, 9) == 0)
                d -= $urandom_range(0, 500);
            else
                d += $urandom_range(0, 2500);
        end
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 3))
            0:       push_req(random_req(OP_LOAD));
            1:       push_req(random_req(OP_REARM));
            2:       push_req(random_req(OP_UNUSED));
            default: push_req(random_req(OP_TICK));
        endcase
    endtask

    initial
    begin : stimulus
        int ticks;
        int window;
        int volume;
        int count;

        next_idx   = 0;
        lap_wait   = 1'b0;
        slots_used = 0;
        ch_gain    = '{default: '0};
        slot_left  = '{default: '0};
        slot_ch    = '{default: 1'b0};
        cfg_ticks  = PLAY_TICKS_RST;
        cfg_window = NEW_LAP_WINDOW_RST;
        cfg_volume = CUE_VOLUME_RST;
        cfg_count  = MARKER_COUNT_RST;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Empty table, unknown opcode, distance extremes, then a loaded table
        push_req(random_req(OP_UNUSED));
        push_tick(-8388608);
        push_tick(8388607);
        push_req(random_req(OP_REARM));
        push_tick(1);
        push_load(0, -8388608, 1'b0);
        push_load(1, -1, 1'b1);
        push_load(2, 0, 1'b0);
        push_load(3, 8388607, 1'b1);
        push_load(63, 8388607, 1'b1);
        push_load(63, -8388608, 1'b0);
        settle();

        set_config(2, 1000, 255, 4);
        push_req(random_req(OP_REARM));
        push_tick(-8388608);
        push_tick(-8388607);
        push_tick(0);
        push_tick(0);
        push_tick(1);
        push_tick(8388607);
        push_tick(8388607);
        push_tick(8388607);
        push_req(random_req(OP_REARM));
        push_tick(5);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 3))
                0:       ticks = 0;
                1:       ticks = 31;
                2:       ticks = 1;
                default: ticks = $urandom_range(1, 31);
            endcase
            case ($urandom_range(0, 5))
                0:       window = 0;
                1:       window = (1 << WINDOW_W) - 1;
                2:       window = 100000;
                default: window = $urandom_range(500, 20000);
            endcase
            case ($urandom_range(0, 2))
                0:       volume = 0;
                1:       volume = 255;
                default: volume = $urandom_range(1, 254);
            endcase
            case ($urandom_range(0, 6))
                0:       count = 0;
                1:       count = 1;
                2:       count = MAX_MARKERS;
                3:       count = (p % 2 == 0) ? MAX_MARKERS + 1 : (1 << COUNT_W) - 1;
                default: count = $urandom_range(2, 40);
            endcase
            // fill all sixteen slots while cues are still sounding
            if (p == 1)
            begin
                ticks = 31;
                count = 40;
            end
            set_config(ticks, window, volume, count);
            pace       = pace_t'(p % 4);
            phase_reqs = 0;
            fill_markers();
            while (phase_reqs < PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_noise();
                else
                    run_lap();
            end
            if (p == 4)
                hold_start = 1'b1;
            settle();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
